// ===== src/vbac_pkg.sv =====
// shared types, codes and constants of the volume, balance and mute controller
package vbac_pkg;

   localparam logic [6:0]        VOL_MAX   = 7'd79;
   localparam logic [6:0]        VOL_STEP  = 7'd3;
   localparam logic [6:0]        VOL_RESET = 7'd19;
   localparam logic signed [5:0] BAL_MIN   = -6'sd20;
   localparam logic signed [5:0] BAL_MAX   = 6'sd20;

   localparam logic [7:0] CH_LEFT  = 8'h80;
   localparam logic [7:0] CH_RIGHT = 8'h00;
   localparam logic [7:0] CMD_10DB = 8'h30;
   localparam logic [7:0] CMD_1DB  = 8'h20;

   // reciprocal of 20 scaled by 2^16, exact for sums below 2048
   localparam logic [11:0] RECIP20 = 12'd3277;
   localparam int          RECIP20_SHIFT = 16;
   // reciprocal of 10 scaled by 2^11, exact for values below 80
   localparam logic [7:0]  RECIP10 = 8'd205;

   localparam int QUEUE_DEPTH = 2;

   // register addresses (word index)
   localparam logic REG_SWAP_SIDES = 1'b0;

   typedef enum logic [2:0] {
      FUNC_PRESET   = 3'd0,
      FUNC_VOL_UP   = 3'd1,
      FUNC_VOL_DOWN = 3'd2,
      FUNC_BAL_RIGHT = 3'd3,
      FUNC_BAL_LEFT = 3'd4,
      FUNC_MUTE     = 3'd5
   } func_type;

   // one event after classification: state snapshot and what to emit
   typedef struct packed {
      logic              pair;      // emit left and right commands
      logic              changed;
      logic [6:0]        volume;
      logic signed [5:0] balance;
      logic              mute;
   } job_type;

endpackage

// ===== src/vbac_front.sv =====
// front end: applies each event to the volume, balance and mute state
module vbac_front import vbac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [2:0]        func,
   input  logic [7:0]        preset_volume,
   input  logic signed [7:0] preset_balance,
   input  logic              preset_mute,
   output logic              push_valid,
   input  logic              push_ready,
   output job_type           push_job
);

   logic [6:0]        vol_ff, vol_in;
   logic signed [5:0] bal_ff, bal_in;
   logic              mute_ff, mute_in;
   logic              changed;
   logic              pair;
   logic              accept;

   assign accept     = req_valid && push_ready;
   assign push_valid = req_valid;

   always_comb begin
      vol_in  = vol_ff;
      bal_in  = bal_ff;
      mute_in = mute_ff;
      changed = 1'b0;
      pair    = 1'b0;
      case (func_type'(func))
         FUNC_PRESET: begin
            vol_in  = (preset_volume > 8'(VOL_MAX)) ? VOL_MAX : preset_volume[6:0];
            if (preset_balance < BAL_MIN) begin
               bal_in = BAL_MIN;
            end else if (preset_balance > BAL_MAX) begin
               bal_in = BAL_MAX;
            end else begin
               bal_in = preset_balance[5:0];
            end
            mute_in = preset_mute;
            changed = (vol_in != vol_ff) || (bal_in != bal_ff) || (mute_in != mute_ff);
            pair    = 1'b1;
         end
         FUNC_VOL_UP: begin
            vol_in  = (vol_ff >= VOL_MAX - VOL_STEP) ? VOL_MAX : vol_ff + VOL_STEP;
            changed = vol_in != vol_ff;
            pair    = changed;
         end
         FUNC_VOL_DOWN: begin
            // from the top level the first step down is a single notch
            if (vol_ff == VOL_MAX) begin
               vol_in = VOL_MAX - 7'd1;
            end else if (vol_ff < VOL_STEP) begin
               vol_in = '0;
            end else begin
               vol_in = vol_ff - VOL_STEP;
            end
            changed = vol_in != vol_ff;
            pair    = changed;
         end
         FUNC_BAL_RIGHT: begin
            bal_in  = (bal_ff == BAL_MAX) ? BAL_MAX : bal_ff + 6'sd1;
            changed = bal_in != bal_ff;
            pair    = changed;
         end
         FUNC_BAL_LEFT: begin
            bal_in  = (bal_ff == BAL_MIN) ? BAL_MIN : bal_ff - 6'sd1;
            changed = bal_in != bal_ff;
            pair    = changed;
         end
         FUNC_MUTE: begin
            mute_in = !mute_ff;
            changed = mute_in;
            pair    = 1'b1;
         end
         default: begin
            changed = 1'b0;
            pair    = 1'b0;
         end
      endcase
   end

   assign push_job.pair    = pair;
   assign push_job.changed = changed;
   assign push_job.volume  = vol_in;
   assign push_job.balance = bal_in;
   assign push_job.mute    = mute_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff  <= VOL_RESET;
         bal_ff  <= '0;
         mute_ff <= 1'b0;
      end else if (accept) begin
         vol_ff  <= vol_in;
         bal_ff  <= bal_in;
         mute_ff <= mute_in;
      end
   end

endmodule

// ===== src/vbac_queue.sv =====
// short job queue between the front end and the command back end
module vbac_queue import vbac_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_job   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

// ===== src/vbac_back.sv =====
// back end: channel levels, attenuation digits and result sequencing
module vbac_back import vbac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        swap_sides,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_changed,
   output logic        rsp_cmd_valid,
   output logic        rsp_right_side,
   output logic [7:0]  rsp_tens_cmd,
   output logic [7:0]  rsp_ones_cmd,
   output logic [6:0]  rsp_cur_volume,
   output logic [5:0]  rsp_cur_balance,
   output logic        rsp_cur_mute,
   output logic        rsp_last
);

   // level clamped to 0..79, zero when muted, turned into attenuation
   function automatic logic [6:0] atten_db(input logic signed [8:0] lvl, input logic mute);
      logic [6:0] level;
      if (mute || lvl < 9'sd0) begin
         level = '0;
      end else if (lvl > signed'(9'(VOL_MAX))) begin
         level = VOL_MAX;
      end else begin
         level = lvl[6:0];
      end
      return VOL_MAX - level;
   endfunction

   function automatic logic [3:0] tens_of(input logic [6:0] db);
      logic [14:0] m;
      m = 15'(db) * 15'(RECIP10);
      return m[14:11];
   endfunction

   function automatic logic [3:0] ones_of(input logic [6:0] db, input logic [3:0] tens);
      logic [6:0] rest;
      rest = db - (7'({tens, 3'b000}) + 7'({tens, 1'b0}));
      return rest[3:0];
   endfunction

   // stage 1: volume times balance
   logic               s1_v_ff, s1_v_in;
   job_type            s1_job_ff;
   logic signed [12:0] s1_prod_ff;
   // stage 2: rounded offset
   logic               s2_v_ff, s2_v_in;
   job_type            s2_job_ff;
   logic signed [7:0]  s2_r_ff;
   // stage 3: attenuation per channel
   logic               s3_v_ff, s3_v_in;
   job_type            s3_job_ff;
   logic [6:0]         s3_db_l_ff, s3_db_r_ff;
   // output register
   logic               o_v_ff, o_v_in;
   logic               o_side_ff, o_side_in;
   job_type            o_job_ff;
   logic [3:0]         o_tens_l_ff, o_ones_l_ff, o_tens_r_ff, o_ones_r_ff;

   logic               o_last;
   logic               o_free;
   logic               s3_acc, s2_acc, s1_acc;
   logic signed [12:0] vol_ext, bal_ext, prod;
   logic [12:0]        prod_abs;
   logic [10:0]        rnd_sum;
   logic [22:0]        rnd_mul;
   logic [6:0]         rnd_q;
   logic signed [7:0]  r_val;
   logic signed [8:0]  lvl_vol, lvl_r, lvl_up, lvl_dn;
   logic [6:0]         db_l, db_r;
   logic [3:0]         tens_l, tens_r;

   assign o_last = !o_job_ff.pair || o_side_ff;
   assign o_free = !o_v_ff || (rsp_ready && o_last);
   assign s3_acc = !s3_v_ff || o_free;
   assign s2_acc = !s2_v_ff || s3_acc;
   assign s1_acc = !s1_v_ff || s2_acc;
   assign job_ready = s1_acc;

   // stage 1 datapath
   assign vol_ext = 13'(signed'({1'b0, job.volume}));
   assign bal_ext = 13'(job.balance);
   assign prod    = vol_ext * bal_ext;

   // stage 2 datapath: round half away from zero of |p|/20
   assign prod_abs = s1_prod_ff[12] ? 13'(-s1_prod_ff) : 13'(s1_prod_ff);
   assign rnd_sum  = prod_abs[10:0] + 11'd10;
   assign rnd_mul  = 23'(rnd_sum) * 23'(RECIP20);
   assign rnd_q    = rnd_mul[RECIP20_SHIFT +: 7];
   assign r_val    = s1_prod_ff[12] ? -signed'({1'b0, rnd_q}) : signed'({1'b0, rnd_q});

   // stage 3 datapath
   assign lvl_vol = signed'({2'b00, s2_job_ff.volume});
   assign lvl_r   = 9'(s2_r_ff);
   assign lvl_up  = lvl_vol + lvl_r;
   assign lvl_dn  = lvl_vol - lvl_r;
   assign db_l    = atten_db(swap_sides ? lvl_up : lvl_dn, s2_job_ff.mute);
   assign db_r    = atten_db(swap_sides ? lvl_dn : lvl_up, s2_job_ff.mute);

   // digits for the output register
   assign tens_l = tens_of(s3_db_l_ff);
   assign tens_r = tens_of(s3_db_r_ff);

   always_comb begin
      s1_v_in   = s1_acc ? job_valid : s1_v_ff;
      s2_v_in   = s2_acc ? s1_v_ff : s2_v_ff;
      s3_v_in   = s3_acc ? s2_v_ff : s3_v_ff;
      o_v_in    = o_v_ff;
      o_side_in = o_side_ff;
      if (o_free) begin
         o_v_in    = s3_v_ff;
         o_side_in = 1'b0;
      end else if (o_v_ff && rsp_ready) begin
         o_side_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         o_v_ff    <= 1'b0;
         o_side_ff <= 1'b0;
      end else begin
         s1_v_ff   <= s1_v_in;
         s2_v_ff   <= s2_v_in;
         s3_v_ff   <= s3_v_in;
         o_v_ff    <= o_v_in;
         o_side_ff <= o_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_acc) begin
         s1_job_ff  <= job;
         s1_prod_ff <= prod;
      end
      if (s2_acc) begin
         s2_job_ff <= s1_job_ff;
         s2_r_ff   <= r_val;
      end
      if (s3_acc) begin
         s3_job_ff  <= s2_job_ff;
         s3_db_l_ff <= db_l;
         s3_db_r_ff <= db_r;
      end
      if (o_free) begin
         o_job_ff    <= s3_job_ff;
         o_tens_l_ff <= tens_l;
         o_ones_l_ff <= ones_of(s3_db_l_ff, tens_l);
         o_tens_r_ff <= tens_r;
         o_ones_r_ff <= ones_of(s3_db_r_ff, tens_r);
      end
   end

   always_comb begin
      rsp_valid       = o_v_ff;
      rsp_last        = o_last;
      rsp_cur_volume  = o_job_ff.volume;
      rsp_cur_balance = o_job_ff.balance;
      rsp_cur_mute    = o_job_ff.mute;
      if (o_job_ff.pair) begin
         rsp_changed    = o_job_ff.changed;
         rsp_cmd_valid  = 1'b1;
         rsp_right_side = o_side_ff;
         if (o_side_ff) begin
            rsp_tens_cmd = CH_RIGHT | CMD_10DB | 8'(o_tens_r_ff);
            rsp_ones_cmd = CH_RIGHT | CMD_1DB | 8'(o_ones_r_ff);
         end else begin
            rsp_tens_cmd = CH_LEFT | CMD_10DB | 8'(o_tens_l_ff);
            rsp_ones_cmd = CH_LEFT | CMD_1DB | 8'(o_ones_l_ff);
         end
      end else begin
         rsp_changed    = 1'b0;
         rsp_cmd_valid  = 1'b0;
         rsp_right_side = 1'b0;
         rsp_tens_cmd   = '0;
         rsp_ones_cmd   = '0;
      end
   end

endmodule

// ===== src/volume_balance_attenuator_control.sv =====
// top level of the volume, balance and mute attenuator controller
//
// Each request carries one remote-control event (preset, volume up/down,
// balance right/left, toggle mute). The front end applies it to the stored
// volume (0..79, reset 19), balance (-20..20, reset 0) and mute flag in the
// cycle it is accepted and hands a job to a short queue. The back end works
// the job through three register stages (volume*balance product, rounded
// offset, clamped channel attenuation) into an output register that sends
// the left channel result and then the right one, tlast on the right. A
// volume or balance event that leaves the state as it was gives one result
// with no command. A request is taken every cycle while the queue has room;
// steady-state throughput is set by the single result port carrying one
// channel per cycle while rsp_tready is high, with two results for an event
// that drives commands and one for an event that drives none.
// swap_sides (word 0, reset 1) picks which channel a positive balance
// raises; write it only while the block is idle.
module volume_balance_attenuator_control import vbac_pkg::*; #(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // preset_volume[7:0], preset_balance[15:8],
                                    // preset_mute[16], zero fill
   input  logic [2:0]  req_tuser,   // func[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // changed[0], tens_cmd[8:1], ones_cmd[16:9],
                                    // cur_volume[23:17], cur_balance[29:24],
                                    // cur_mute[30], zero fill
   output logic [1:0]  rsp_tuser,   // cmd_valid[0], right_side[1]
   output logic        rsp_tlast,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic        swap_ff, swap_in;
   logic        csr_write;

   logic        push_valid, push_ready;
   job_type     push_job;
   logic        pop_valid, pop_ready;
   job_type     pop_job;

   logic        r_changed, r_cmd_valid, r_right_side, r_mute, r_last;
   logic [7:0]  r_tens, r_ones;
   logic [6:0]  r_volume;
   logic [5:0]  r_balance;

   // register port: one word, always ready
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign swap_in    = (csr_write && csr_paddr[2] == REG_SWAP_SIDES) ? csr_pwdata[0] : swap_ff;
   assign csr_prdata = (csr_paddr[2] == REG_SWAP_SIDES) ? {31'b0, swap_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff <= 1'b1;
      end else begin
         swap_ff <= swap_in;
      end
   end

   // request accepted whenever the queue has room
   assign req_tready = push_ready;

   vbac_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .func           (req_tuser),
      .preset_volume  (req_tdata[7:0]),
      .preset_balance (req_tdata[15:8]),
      .preset_mute    (req_tdata[16]),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_job       (push_job)
   );

   vbac_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_job    (push_job),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_job   (pop_job)
   );

   vbac_back u_back (
      .clock           (clock),
      .reset           (reset),
      .swap_sides      (swap_ff),
      .job_valid       (pop_valid),
      .job_ready       (pop_ready),
      .job             (pop_job),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_changed     (r_changed),
      .rsp_cmd_valid   (r_cmd_valid),
      .rsp_right_side  (r_right_side),
      .rsp_tens_cmd    (r_tens),
      .rsp_ones_cmd    (r_ones),
      .rsp_cur_volume  (r_volume),
      .rsp_cur_balance (r_balance),
      .rsp_cur_mute    (r_mute),
      .rsp_last        (r_last)
   );

   // pack result fields, lowest bit first
   assign rsp_tdata = {1'b0, r_mute, r_balance, r_volume, r_ones, r_tens, r_changed};
   assign rsp_tuser = {r_right_side, r_cmd_valid};
   assign rsp_tlast = r_last;

endmodule
